### rtl/core/mpd_pkg.sv
package mpd_pkg;

  // descriptor store depth default
  localparam int MAX_SDUS_DEF = 255;

  // field widths
  localparam int BYTE_W   = 8;
  localparam int INDEX_W  = 8;
  localparam int LEN_W    = 15;
  localparam int ADDR_W   = 4;
  localparam int HDR_W    = 9;
  localparam int PAYLD_W  = 23;
  localparam int DESC_W   = 16;
  localparam int M_DATA_W = 48;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_addr;    // address byte of a new pdu
    logic load_count;   // sdu count byte
    logic desc_byte;    // one descriptor byte
    logic seek_start;   // header done, scan from sdu zero
    logic mem_rd;       // read descriptor at current sdu
    logic next_sdu;     // step to the following sdu
    logic load_sdu;     // take the read descriptor as the current sdu
    logic emit_byte;    // send a payload byte
    logic emit_marker;  // send the empty pdu marker
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic count_zero;   // incoming count byte is zero
    logic desc_second;  // incoming descriptor byte is the low one of its pair
    logic desc_done;    // this pair is the last descriptor
    logic sum_zero;     // payload total including this pair is zero
    logic rd_len_zero;  // read descriptor has zero size
    logic sdu_end;      // next payload byte closes the current sdu
    logic last_pdu;     // next payload byte closes the pdu
    logic out_free;     // output register can take a result
  } status_t;

endpackage

### rtl/core/mpd_ctrl.sv
module mpd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_first,
  output logic             in_ready,
  input  mpd_pkg::status_t st,
  output mpd_pkg::cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_COUNT    = 3'd1;
  localparam logic [2:0] ST_DESC     = 3'd2;
  localparam logic [2:0] ST_SEEK_RD  = 3'd3;
  localparam logic [2:0] ST_SEEK_CHK = 3'd4;
  localparam logic [2:0] ST_PAYLOAD  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       fire;

  // input is taken only in parsing phases and with room at the output
  assign in_ready = (state == ST_IDLE || state == ST_COUNT || state == ST_DESC ||
                     state == ST_PAYLOAD) && st.out_free;
  assign fire = in_valid && in_ready;

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    if (fire && in_first) begin
      cmd.load_addr = 1'b1;
      state_next    = ST_COUNT;
    end else begin
      unique case (state)
        ST_IDLE: begin
          state_next = ST_IDLE;
        end
        ST_COUNT: begin
          if (fire) begin
            cmd.load_count = 1'b1;
            if (st.count_zero) begin
              cmd.emit_marker = 1'b1;
              state_next      = ST_IDLE;
            end else begin
              state_next = ST_DESC;
            end
          end
        end
        ST_DESC: begin
          if (fire) begin
            cmd.desc_byte = 1'b1;
            if (st.desc_second && st.desc_done) begin
              if (st.sum_zero) begin
                cmd.emit_marker = 1'b1;
                state_next      = ST_IDLE;
              end else begin
                cmd.seek_start = 1'b1;
                state_next     = ST_SEEK_RD;
              end
            end
          end
        end
        ST_SEEK_RD: begin
          cmd.mem_rd = 1'b1;
          state_next = ST_SEEK_CHK;
        end
        ST_SEEK_CHK: begin
          if (st.rd_len_zero) begin
            cmd.next_sdu = 1'b1;
            state_next   = ST_SEEK_RD;
          end else begin
            cmd.load_sdu = 1'b1;
            state_next   = ST_PAYLOAD;
          end
        end
        ST_PAYLOAD: begin
          if (fire) begin
            cmd.emit_byte = 1'b1;
            if (st.last_pdu) begin
              state_next = ST_IDLE;
            end else if (st.sdu_end) begin
              // current sdu ends with this byte
              cmd.next_sdu = 1'b1;
              state_next   = ST_SEEK_RD;
            end
          end
        end
        default: begin
          state_next = ST_IDLE;
        end
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  // no input is taken while the descriptor scan runs
  a_no_take_in_seek: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEEK_RD || state == ST_SEEK_CHK) |-> !in_ready)
    else $error("input accepted during descriptor scan");

  // a read is always followed by its check
  a_rd_then_chk: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_rd |=> state == ST_SEEK_CHK)
    else $error("descriptor read not followed by check");

  // a marker always returns the parser to idle
  a_marker_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_marker |=> state == ST_IDLE)
    else $error("marker without return to idle");
`endif

endmodule

### rtl/core/mpd_datapath.sv
module mpd_datapath #(
  parameter int MAX_SDUS = mpd_pkg::MAX_SDUS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [mpd_pkg::BYTE_W-1:0]    in_byte,
  input  mpd_pkg::cmd_t                 cmd,
  output mpd_pkg::status_t              st,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mpd_pkg::M_DATA_W-1:0]  out_data,
  output logic                          out_byte_valid,
  output logic                          out_last_pdu
);

  localparam int AW = (MAX_SDUS > 1) ? $clog2(MAX_SDUS) : 1;
  localparam logic [mpd_pkg::INDEX_W-1:0] MAX_CNT = mpd_pkg::INDEX_W'(MAX_SDUS);
  localparam int PAD_W = mpd_pkg::M_DATA_W - (2 * mpd_pkg::BYTE_W + mpd_pkg::LEN_W +
                                               2 + 2 * mpd_pkg::ADDR_W);

  // pdu header and scan registers
  logic [mpd_pkg::ADDR_W-1:0]  src_addr;
  logic [mpd_pkg::ADDR_W-1:0]  dst_addr;
  logic [mpd_pkg::INDEX_W-1:0] sdu_total;
  logic [mpd_pkg::HDR_W-1:0]   hdr_cnt;
  logic [mpd_pkg::BYTE_W-1:0]  held_byte;
  logic [mpd_pkg::INDEX_W-1:0] cur_sdu;
  logic [mpd_pkg::LEN_W-1:0]   bytes_left;
  logic [mpd_pkg::PAYLD_W-1:0] payload_left;
  logic                        cur_flag;
  logic [mpd_pkg::LEN_W-1:0]   cur_len;

  // descriptor store
  logic [mpd_pkg::DESC_W-1:0]  desc_mem [MAX_SDUS];
  logic [mpd_pkg::DESC_W-1:0]  rd_data;

  // output register
  logic [mpd_pkg::BYTE_W-1:0]  o_byte;
  logic [mpd_pkg::INDEX_W-1:0] o_idx;
  logic                        o_flag;
  logic [mpd_pkg::LEN_W-1:0]   o_len;
  logic                        o_lsdu;
  logic [mpd_pkg::ADDR_W-1:0]  o_src;
  logic [mpd_pkg::ADDR_W-1:0]  o_dst;

  logic [mpd_pkg::INDEX_W-1:0] pair_idx;
  logic [mpd_pkg::PAYLD_W-1:0] sum_next;
  logic                        last_sdu;

  assign pair_idx = hdr_cnt[mpd_pkg::HDR_W-1:1];
  assign sum_next = payload_left +
                    {{(mpd_pkg::PAYLD_W - mpd_pkg::LEN_W){1'b0}}, held_byte[6:0], in_byte};
  assign last_sdu = (bytes_left == mpd_pkg::LEN_W'(1));

  // status toward the controller
  always_comb begin
    st.count_zero  = (in_byte == '0);
    st.desc_second = hdr_cnt[0];
    st.desc_done   = ({1'b0, pair_idx} + 9'd1) >= {1'b0, sdu_total};
    st.sum_zero    = (sum_next == '0);
    st.rd_len_zero = (rd_data[mpd_pkg::LEN_W-1:0] == '0);
    st.sdu_end     = last_sdu;
    st.last_pdu    = (payload_left == mpd_pkg::PAYLD_W'(1));
    st.out_free    = !out_valid || out_ready;
  end

  // header parsing and sdu tracking
  always_ff @(posedge clk) begin
    if (cmd.load_addr) begin
      src_addr <= in_byte[7:4];
      dst_addr <= in_byte[3:0];
    end
    if (cmd.load_count) begin
      sdu_total    <= (in_byte > MAX_CNT) ? MAX_CNT : in_byte;
      hdr_cnt      <= '0;
      payload_left <= '0;
    end
    if (cmd.desc_byte) begin
      hdr_cnt <= hdr_cnt + 9'd1;
      if (!hdr_cnt[0]) begin
        held_byte <= in_byte;
      end else begin
        payload_left <= sum_next;
      end
    end
    if (cmd.seek_start) begin
      cur_sdu <= '0;
    end
    if (cmd.next_sdu) begin
      cur_sdu <= cur_sdu + 8'd1;
    end
    if (cmd.load_sdu) begin
      bytes_left <= rd_data[mpd_pkg::LEN_W-1:0];
      cur_len    <= rd_data[mpd_pkg::LEN_W-1:0];
      cur_flag   <= rd_data[mpd_pkg::DESC_W-1];
    end
    if (cmd.emit_byte) begin
      bytes_left   <= bytes_left - mpd_pkg::LEN_W'(1);
      payload_left <= payload_left - mpd_pkg::PAYLD_W'(1);
    end
  end

  // descriptor memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.desc_byte && hdr_cnt[0]) begin
      desc_mem[pair_idx[AW-1:0]] <= {held_byte, in_byte};
    end
    if (cmd.mem_rd) begin
      rd_data <= desc_mem[cur_sdu[AW-1:0]];
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.emit_byte) begin
      o_byte         <= in_byte;
      out_byte_valid <= 1'b1;
      o_idx          <= cur_sdu;
      o_flag         <= cur_flag;
      o_len          <= cur_len;
      o_lsdu         <= last_sdu;
      out_last_pdu   <= st.last_pdu;
      o_src          <= src_addr;
      o_dst          <= dst_addr;
    end else if (cmd.emit_marker) begin
      o_byte         <= '0;
      out_byte_valid <= 1'b0;
      o_idx          <= '0;
      o_flag         <= 1'b0;
      o_len          <= '0;
      o_lsdu         <= 1'b0;
      out_last_pdu   <= 1'b1;
      o_src          <= src_addr;
      o_dst          <= dst_addr;
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_byte || cmd.emit_marker) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_data = {{PAD_W{1'b0}}, o_dst, o_src, o_lsdu, o_len, o_flag, o_idx, o_byte};

`ifndef SYNTHESIS
  // a payload byte is never sent with nothing left in the sdu
  a_emit_has_bytes: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_byte |-> bytes_left != '0)
    else $error("payload byte with empty sdu");

  // the scan only settles on a descriptor with a nonzero size
  a_load_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.load_sdu |-> rd_data[mpd_pkg::LEN_W-1:0] != '0)
    else $error("zero size sdu selected");

  // the final byte of the pdu also closes its sdu
  a_pdu_end_sdu_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_byte && st.last_pdu) |-> last_sdu)
    else $error("pdu ends inside an sdu");

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_byte || cmd.emit_marker) |-> st.out_free)
    else $error("result overwritten");
`endif

endmodule

### rtl/core/mac_pdu_deframer.sv
// channel | dir | tdata                        | tuser      | tlast
// s_*     | in  | data_byte                    | first_byte | -
// m_*     | out | sdu_byte .. dest (see port)  | byte_valid | last_of_pdu
//
// header and payload bytes: one per cycle while m_tready keeps up
// each sdu start stalls the input for a descriptor read (SEEK_RD, then SEEK_CHK) on
// the single memory read port, repeated for every zero-size sdu passed over
// rst is synchronous; the descriptor store needs no clearing pass
// a result waiting in the output register stalls s_tready only if m_tready is low
module mac_pdu_deframer #(
  parameter int MAX_SDUS = mpd_pkg::MAX_SDUS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // data_byte[7:0]
  input  logic                         s_tuser,   // first_byte
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // sdu_byte[7:0], sdu_index[15:8], is_data[16], sdu_length[31:17],
  // last_of_sdu[32], source_address[36:33], destination_address[40:37]
  output logic [mpd_pkg::M_DATA_W-1:0] m_tdata,
  output logic                         m_tuser,   // byte_valid
  output logic                         m_tlast    // last_of_pdu
);

  mpd_pkg::cmd_t    cmd;
  mpd_pkg::status_t st;

  // parsing controller
  mpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_first (s_tuser),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // descriptor store, counters and output register
  mpd_datapath #(
    .MAX_SDUS (MAX_SDUS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .in_byte        (s_tdata),
    .cmd            (cmd),
    .st             (st),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_data       (m_tdata),
    .out_byte_valid (m_tuser),
    .out_last_pdu   (m_tlast)
  );

endmodule
